@@ design/pse_pkg.sv @@
// Package for the priority store: command and status codes, compare-unit result type.
// No dependencies; pse_cmp and the top level refer to it by scoped name.
package pse_pkg;

    typedef logic [2:0] cmd_t;
    typedef logic [2:0] status_t;

    localparam cmd_t CMD_ADD      = 3'd0;
    localparam cmd_t CMD_POP      = 3'd1;
    localparam cmd_t CMD_REMOVE   = 3'd2;
    localparam cmd_t CMD_CONTAINS = 3'd3;
    localparam cmd_t CMD_READ     = 3'd4;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_DUPLICATE = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_BAD_INDEX = 3'd4;

    localparam int PRIO_W  = 16;
    localparam int VALUE_W = 32;
    localparam int ENTRY_W = PRIO_W + VALUE_W;

    typedef struct packed {
        logic prio_eq;
        logic value_eq;
        logic prio_gt;
    } cmp_t;

endpackage

@@ design/pse_cmd_if.sv @@
// Command channel of the priority store: valid/ready and one command word.
// Depends on nothing.
interface pse_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [15:0] priority_req;
    logic signed [31:0] value;
    logic [3:0]         index;

    modport source (output valid, cmd, priority_req, value, index, input ready);
    modport sink   (input valid, cmd, priority_req, value, index, output ready);
endinterface

@@ design/pse_res_if.sv @@
// Result channel of the priority store: valid/ready and one result word.
// Depends on nothing.
interface pse_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic               found;
    logic signed [15:0] out_priority;
    logic signed [31:0] out_value;
    logic [4:0]         removed_count;
    logic [4:0]         count;

    modport source (output valid, status, found, out_priority, out_value, removed_count,
                    count, input ready);
    modport sink   (input valid, status, found, out_priority, out_value, removed_count,
                    count, output ready);
endinterface

@@ design/pse_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module pse_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/pse_cmp.sv @@
// Shared compare unit: equality of priority and value, signed greater-than on priority.
// Depends on pse_pkg.
module pse_cmp (
    input  logic [pse_pkg::PRIO_W-1:0]  a_prio,
    input  logic [pse_pkg::VALUE_W-1:0] a_value,
    input  logic [pse_pkg::PRIO_W-1:0]  b_prio,
    input  logic [pse_pkg::VALUE_W-1:0] b_value,
    output pse_pkg::cmp_t               res
);

    always_comb
    begin
        res.prio_eq  = (a_prio == b_prio);
        res.value_eq = (a_value == b_value);
        res.prio_gt  = ($signed(a_prio) > $signed(b_prio));
    end

endmodule

@@ design/priority_store_max_extract.sv @@
// Top level of the priority store: sequencer, scan registers and result register.
// Depends on pse_pkg, pse_cmd_if, pse_res_if, pse_ram and pse_cmp.
//
//  channel   dir   handshake                 word
//  cmd_ch    in    valid/ready               cmd, priority_req, value, index
//  res_ch    out   valid/ready               status, found, out_priority, out_value,
//                                            removed_count, count
//  cfg       in    cfg_we                    cfg_wdata (capacity_in_use)
//
// Add, pop, remove-all and contains scan every held entry: one RAM read per held entry
// through the single read port, then a drain step, then a step to commit the result.
// Read fetches only the given slot, and only when it is below the count; other codes read none.
// cmd_ch.ready is high only between commands. A stalled result holds the commit step.
// rst_n clears the count and sets the capacity to 16; RAM contents need no clearing.
module priority_store_max_extract #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    pse_cmd_if.sink        cmd_ch,
    pse_res_if.source      res_ch,
    input  logic           cfg_we,
    input  logic [4:0]     cfg_wdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = pse_pkg::PRIO_W;
    localparam int VW = pse_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    pse_pkg::cmd_t    cmd_reg;
    logic [PW-1:0]    preq_reg;
    logic [VW-1:0]    val_reg;
    logic [3:0]       idx_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [4:0]       cap_reg;
    logic [XW-1:0]    ptr_reg, ptr_next;
    logic [XW-1:0]    end_reg, end_next;
    logic             dv_reg;
    logic [AW-1:0]    didx_reg;
    logic [CW-1:0]    keep_reg, keep_next;
    logic             hit_reg, hit_next;
    logic [AW-1:0]    best_idx_reg, best_idx_next;
    logic [PW-1:0]    best_prio_reg, best_prio_next;
    logic [VW-1:0]    best_val_reg, best_val_next;
    logic [PW-1:0]    last_prio_reg, last_prio_next;
    logic [VW-1:0]    last_val_reg, last_val_next;

    logic                    out_valid_reg;
    pse_pkg::status_t        out_status_reg;
    logic                    out_found_reg;
    logic [PW-1:0]           out_prio_reg;
    logic [VW-1:0]           out_val_reg;
    logic [4:0]              out_removed_reg;
    logic [4:0]              out_count_reg;

    logic                        in_fire;
    logic                        out_free;
    logic                        commit;
    logic                        rd_en;
    logic [pse_pkg::ENTRY_W-1:0] rd_data;
    logic [PW-1:0]               rd_prio;
    logic [VW-1:0]               rd_val;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [pse_pkg::ENTRY_W-1:0] ram_wdata;
    logic [PW-1:0]               cmp_b_prio;
    pse_pkg::cmp_t               cmp_res;
    logic [XW-1:0]               count_x;
    logic [XW-1:0]               idx_x;
    logic [XW-1:0]               cap_x;
    logic [XW-1:0]               limit_x;
    logic [XW-1:0]               in_idx_x;

    pse_pkg::status_t        r_status;
    logic                    r_found;
    logic [PW-1:0]           r_prio;
    logic [VW-1:0]           r_val;
    logic [XW-1:0]           r_removed;
    logic [XW-1:0]           r_count_x;

    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign in_fire      = cmd_ch.valid && cmd_ch.ready;
    assign out_free     = !out_valid_reg || res_ch.ready;
    assign commit       = (state_reg == S_FINISH) && out_free;

    assign count_x  = XW'(count_reg);
    assign idx_x    = XW'(idx_reg);
    assign in_idx_x = XW'(cmd_ch.index);
    assign cap_x    = XW'(cap_reg);
    assign limit_x  = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;

    assign rd_en   = (state_reg == S_SCAN) && (ptr_reg < end_reg);
    assign rd_prio = rd_data[pse_pkg::ENTRY_W-1:VW];
    assign rd_val  = rd_data[VW-1:0];

    assign cmp_b_prio = (cmd_reg == pse_pkg::CMD_POP) ? best_prio_reg : preq_reg;

    pse_ram #(
        .WIDTH (pse_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    pse_cmp u_cmp (
        .a_prio  (rd_prio),
        .a_value (rd_val),
        .b_prio  (cmp_b_prio),
        .b_value (val_reg),
        .res     (cmp_res)
    );

    always_comb
    begin
        r_status  = pse_pkg::ST_OK;
        r_found   = 1'b0;
        r_prio    = '0;
        r_val     = '0;
        r_removed = '0;
        r_count_x = count_x;
        ram_we    = 1'b0;
        ram_waddr = keep_reg[AW-1:0];
        ram_wdata = {rd_prio, rd_val};
        if (state_reg == S_SCAN)
        begin
            if (dv_reg && (cmd_reg == pse_pkg::CMD_REMOVE) && !cmp_res.prio_eq)
            begin
                ram_we = 1'b1;
            end
        end
        else if (state_reg == S_FINISH)
        begin
            case (cmd_reg)
                pse_pkg::CMD_ADD:
                begin
                    if (hit_reg)
                    begin
                        r_status = pse_pkg::ST_DUPLICATE;
                    end
                    else if (count_x >= limit_x)
                    begin
                        r_status = pse_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we    = commit;
                        ram_waddr = count_reg[AW-1:0];
                        ram_wdata = {preq_reg, val_reg};
                        r_count_x = count_x + XW'(1);
                    end
                end
                pse_pkg::CMD_POP:
                begin
                    if (count_reg == '0)
                    begin
                        r_status = pse_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        r_found   = 1'b1;
                        r_prio    = best_prio_reg;
                        r_val     = best_val_reg;
                        ram_we    = commit;
                        ram_waddr = best_idx_reg;
                        ram_wdata = {last_prio_reg, last_val_reg};
                        r_count_x = count_x - XW'(1);
                    end
                end
                pse_pkg::CMD_REMOVE:
                begin
                    r_removed = count_x - XW'(keep_reg);
                    r_count_x = XW'(keep_reg);
                end
                pse_pkg::CMD_CONTAINS:
                begin
                    r_found = hit_reg;
                end
                pse_pkg::CMD_READ:
                begin
                    if (idx_x < count_x)
                    begin
                        r_found = 1'b1;
                        r_prio  = best_prio_reg;
                        r_val   = best_val_reg;
                    end
                    else
                    begin
                        r_status = pse_pkg::ST_BAD_INDEX;
                    end
                end
                default:
                begin
                    r_status = pse_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        keep_next      = keep_reg;
        hit_next       = hit_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_val_next  = best_val_reg;
        last_prio_next = last_prio_reg;
        last_val_next  = last_val_reg;
        count_next     = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    keep_next = '0;
                    hit_next  = 1'b0;
                    ptr_next  = '0;
                    end_next  = '0;
                    if (cmd_ch.cmd inside {pse_pkg::CMD_ADD, pse_pkg::CMD_POP,
                                           pse_pkg::CMD_REMOVE, pse_pkg::CMD_CONTAINS})
                    begin
                        end_next = count_x;
                    end
                    else if (cmd_ch.cmd == pse_pkg::CMD_READ)
                    begin
                        ptr_next = in_idx_x;
                        end_next = (in_idx_x < count_x) ? in_idx_x + XW'(1) : in_idx_x;
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    ptr_next = ptr_reg + XW'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
                if (dv_reg)
                begin
                    case (cmd_reg)
                        pse_pkg::CMD_ADD, pse_pkg::CMD_CONTAINS:
                        begin
                            if (cmp_res.prio_eq && cmp_res.value_eq)
                            begin
                                hit_next = 1'b1;
                            end
                        end
                        pse_pkg::CMD_POP:
                        begin
                            if ((didx_reg == '0) || cmp_res.prio_gt)
                            begin
                                best_idx_next  = didx_reg;
                                best_prio_next = rd_prio;
                                best_val_next  = rd_val;
                            end
                            last_prio_next = rd_prio;
                            last_val_next  = rd_val;
                        end
                        pse_pkg::CMD_REMOVE:
                        begin
                            if (!cmp_res.prio_eq)
                            begin
                                keep_next = keep_reg + CW'(1);
                            end
                        end
                        pse_pkg::CMD_READ:
                        begin
                            best_prio_next = rd_prio;
                            best_val_next  = rd_val;
                        end
                        default:
                        begin
                            hit_next = hit_reg;
                        end
                    endcase
                end
            end
            S_FINISH:
            begin
                if (commit)
                begin
                    count_next = r_count_x[CW-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= 5'd16;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dv_reg    <= rd_en;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= cmd_ch.cmd;
            preq_reg <= cmd_ch.priority_req;
            val_reg  <= cmd_ch.value;
            idx_reg  <= cmd_ch.index;
        end
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        didx_reg      <= ptr_reg[AW-1:0];
        keep_reg      <= keep_next;
        hit_reg       <= hit_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_val_reg  <= best_val_next;
        last_prio_reg <= last_prio_next;
        last_val_reg  <= last_val_next;
        if (commit)
        begin
            out_status_reg  <= r_status;
            out_found_reg   <= r_found;
            out_prio_reg    <= r_prio;
            out_val_reg     <= r_val;
            out_removed_reg <= r_removed[4:0];
            out_count_reg   <= r_count_x[4:0];
        end
    end

    assign res_ch.valid         = out_valid_reg;
    assign res_ch.status        = out_status_reg;
    assign res_ch.found         = out_found_reg;
    assign res_ch.out_priority  = out_prio_reg;
    assign res_ch.out_value     = out_val_reg;
    assign res_ch.removed_count = out_removed_reg;
    assign res_ch.count         = out_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_SCAN)) |-> (cmd_reg == pse_pkg::CMD_REMOVE))
        else $error("RAM write during scan outside remove-all");

    a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (XW'(keep_reg) <= ptr_reg))
        else $error("compaction write slot ahead of read slot");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !dv_reg)
        else $error("read data pending at commit");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_ch.valid) |-> ($past(state_reg) == S_FINISH))
        else $error("result raised outside commit");
`endif

endmodule
